// ----- sv/pac_pkg.sv -----
// Package for the pitot airspeed conditioner: field widths, codes, register
// indexes and reset values. No dependencies.
package pac_pkg;

  localparam int CMD_W    = 2;
  localparam int CH_W     = 2;
  localparam int SAMPLE_W = 13;
  localparam int SPEED_W  = 16;
  localparam int ACC_W    = 18;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_NUM_AVG      = 64;
  localparam int DEF_MAX_CHANNELS = 4;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OFFSET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ARM    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_OF_SOUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_KEEP    = 2'd3;

  localparam logic [2:0]  RST_NUM_CHANNELS   = 3'd1;
  localparam logic [15:0] RST_SPEED_OF_SOUND = 16'd21760;
  localparam logic [31:0] RST_PRESSURE_SCALE = 32'd0;
  localparam logic [15:0] RST_FILTER_KEEP    = 16'd45875;

endpackage

// ----- sv/pitot_airspeed_conditioner_top.sv -----
// Pitot airspeed conditioner, top level: sequencer around one shared 32x32
// multiplier, a bit-serial divider and square root, and the sample ring memory.
// Depends on pac_pkg.

// Each item carries a command (in_tuser), a channel and a millivolt sample.
// Store items (command 0) go into the channel's ring of NUM_AVG samples.
// Set-offset items (command 1) take the ring mean in one pass through the
// multiplier (ring sum times a fixed-point reciprocal of NUM_AVG, exact for
// every possible sum) and then run the airspeed path. Armed items (command 2)
// run the airspeed path, the low-pass filter, the channel accumulator and, on
// the last channel, a bit-serial divide by the channel count for the mean. The
// longest part of the airspeed path is the 7th-root search: 32 result bits,
// each needing six 7-word multiply passes through the shared multiplier plus
// one compare. A zero or negative pressure, or a zero pressure scale, skips
// the path. in_tready is high only while the sequencer is idle; a finished
// result waits in the output register while the next item is taken. After
// reset a clearing pass zeroes the ring memory; no item is taken meanwhile,
// configuration writes are.
module pitot_airspeed_conditioner_top #(
  parameter int NUM_AVG      = pac_pkg::DEF_NUM_AVG,
  parameter int MAX_CHANNELS = pac_pkg::DEF_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] channel, [14:2] sample, [15] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] speed_raw, [31:16] speed_filtered,
                                  // [47:32] speed_average, [60:48] offset_mv, [63:61] zero
  output logic [0:0]  out_tuser   // [0] average_valid
);

  localparam int DEPTH = MAX_CHANNELS * NUM_AVG;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(NUM_AVG);
  localparam int SUMW  = pac_pkg::SAMPLE_W + PW;
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNTW  = $clog2(MAX_CHANNELS + 1);
  localparam int DW    = pac_pkg::ACC_W;
  localparam int DENW  = CNTW;
  localparam int DCW   = $clog2(DW);
  localparam int CLRW  = $clog2(DEPTH + 1);
  // ring mean = (sum * OFS_RECIP) >> OFS_SH
  localparam int OFS_SH = SUMW + PW;
  localparam logic [63:0] OFS_RECIP =
    ((64'd1 << OFS_SH) + 64'(NUM_AVG) - 64'd1) / 64'(NUM_AVG);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_WR, S_OFS, S_DIV, S_AS, S_SQ, S_RMUL, S_RCMP,
    S_SQRT, S_SPD, S_FILT1, S_FILT2, S_ACC, S_OUT
  } state_t;

  state_t st_r;

  // configuration
  logic [2:0]  num_ch_r;
  logic [15:0] sos_r;
  logic [31:0] ps_r;
  logic [15:0] keep_r;

  // per-channel state
  logic [PW-1:0]                  ptr_r  [MAX_CHANNELS];
  logic [SUMW-1:0]                sum_r  [MAX_CHANNELS];
  logic [pac_pkg::SAMPLE_W-1:0]   zoff_r [MAX_CHANNELS];
  logic [pac_pkg::SPEED_W-1:0]    filt_r [MAX_CHANNELS];
  logic [pac_pkg::ACC_W-1:0]      acc_r;

  // item
  logic [pac_pkg::CMD_W-1:0]      cmd_r;
  logic [pac_pkg::CH_W-1:0]       ch_r;
  logic [pac_pkg::SAMPLE_W-1:0]   smp_r;
  logic                           chbad_r;
  logic [pac_pkg::SPEED_W-1:0]    raw_r;
  logic [pac_pkg::SPEED_W-1:0]    avg_r;
  logic                           avgv_r;

  // ring memory
  logic [pac_pkg::SAMPLE_W-1:0] ring_mem [DEPTH];
  logic [pac_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [AW-1:0]                addr_r;
  logic [CLRW-1:0]              clr_r;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [pac_pkg::SAMPLE_W-1:0] mem_wdata;

  // airspeed datapath
  logic [45:0]  base_r;
  logic [91:0]  sq_r;
  logic [1:0]   sqc_r;
  logic [31:0]  pw_r [7];
  logic [31:0]  carry_r;
  logic [2:0]   wi_r;
  logic [2:0]   pass_r;
  logic [31:0]  y_r;
  logic [31:0]  mask_r;
  logic [63:0]  sv_r;
  logic [35:0]  srem_r;
  logic [31:0]  sroot_r;
  logic [4:0]   scnt_r;
  logic [31:0]  t1_r;

  // divider
  logic [DW-1:0]   dnum_r;
  logic [DW-1:0]   dq_r;
  logic [DENW-1:0] dden_r;
  logic [DENW-1:0] drem_r;
  logic [DCW-1:0]  dcnt_r;

  logic [pac_pkg::SPEED_W-1:0] out_raw_r, out_filt_r, out_avg_r;
  logic [pac_pkg::SAMPLE_W-1:0] out_off_r;
  logic out_avgv_r, out_valid_r;

  // input fields
  logic [pac_pkg::CH_W-1:0]     in_ch;
  logic [pac_pkg::SAMPLE_W-1:0] in_smp;
  logic [pac_pkg::CMD_W-1:0]    in_cmd;
  assign in_ch  = in_tdata[1:0];
  assign in_smp = in_tdata[14:2];
  assign in_cmd = in_tuser;

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_off_r, out_avg_r, out_filt_r, out_raw_r};
  assign out_tuser  = out_avgv_r;

  logic [CHW-1:0] idx;
  assign idx = CHW'(ch_r);

  // effective channel count, clamped to 1..MAX_CHANNELS
  logic [CNTW-1:0] cnt;
  always_comb begin
    if (num_ch_r == 3'd0) cnt = CNTW'(1);
    else if (32'(num_ch_r) > MAX_CHANNELS) cnt = CNTW'(MAX_CHANNELS);
    else cnt = CNTW'(num_ch_r);
  end

  logic [AW-1:0] ring_addr;
  assign ring_addr = AW'(idx) * AW'(NUM_AVG) + AW'(ptr_r[idx]);

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [16:0] keep_c;
  assign keep_c = 17'h10000 - {1'b0, keep_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      S_OFS: begin
        mul_a = 32'(sum_r[idx]);
        mul_b = OFS_RECIP[31:0];
      end
      S_AS: begin
        mul_a = 32'(smp_r - zoff_r[idx]);
        mul_b = ps_r;
      end
      S_SQ: begin
        mul_a = sqc_r[1] ? {18'b0, base_r[45:32]} : base_r[31:0];
        mul_b = sqc_r[0] ? {18'b0, base_r[45:32]} : base_r[31:0];
      end
      S_RMUL: begin
        mul_a = pw_r[wi_r];
        mul_b = y_r | mask_r;
      end
      S_SPD: begin
        mul_a = {16'b0, sos_r};
        mul_b = sroot_r;
      end
      S_FILT1: begin
        mul_a = {16'b0, keep_r};
        mul_b = {16'b0, filt_r[idx]};
      end
      S_FILT2: begin
        mul_a = {15'b0, keep_c};
        mul_b = {16'b0, raw_r};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic [63:0] ofs_q;
  assign ofs_q = mul_p >> OFS_SH;

  // power word vs. base^2 * 2^132
  logic [223:0] p_flat;
  logic         p_le;
  always_comb begin
    for (int j = 0; j < 7; j++) p_flat[32*j +: 32] = pw_r[j];
  end
  assign p_le = p_flat <= {sq_r, 132'b0};

  logic [91:0] sq_add;
  always_comb begin
    unique case (sqc_r)
      2'd0:    sq_add = 92'(mul_p);
      2'd3:    sq_add = 92'(mul_p) << 64;
      default: sq_add = 92'(mul_p) << 32;
    endcase
  end

  logic [63:0] mac;
  assign mac = mul_p + {32'b0, carry_r};

  logic [31:0] y_new, mask_nxt;
  assign y_new    = p_le ? (y_r | mask_r) : y_r;
  assign mask_nxt = mask_r >> 1;

  // K = 5 * (Y - 2^28) on the final root
  logic [31:0] kdiff;
  logic [34:0] kval;
  assign kdiff = y_new - 32'h1000_0000;
  assign kval  = ({3'b0, kdiff} << 2) + {3'b0, kdiff};

  // square root step
  logic [35:0] s_rs, s_trial;
  assign s_rs    = {srem_r[33:0], sv_r[63:62]};
  assign s_trial = {2'b00, sroot_r, 2'b01};

  // divider step
  logic [DENW:0] d_rs;
  logic          d_ge;
  assign d_rs = {drem_r, dnum_r[DW-1]};
  assign d_ge = d_rs >= {1'b0, dden_r};

  logic [32:0] f_sum;
  assign f_sum = {1'b0, t1_r} + {1'b0, mul_p[31:0]} + 33'd32768;

  logic [pac_pkg::ACC_W:0]   acc_sum;
  logic [pac_pkg::ACC_W-1:0] acc_sat;
  assign acc_sum = {1'b0, acc_r} + (pac_pkg::ACC_W + 1)'(filt_r[idx]);
  assign acc_sat = acc_sum[pac_pkg::ACC_W] ? pac_pkg::ACC_MAX : acc_sum[pac_pkg::ACC_W-1:0];

  logic [SUMW:0] sum_upd;
  assign sum_upd = {1'b0, sum_r[idx]} - (SUMW + 1)'(rd_data_r) + (SUMW + 1)'(smp_r);

  logic [PW:0] ptr_inc;
  assign ptr_inc = {1'b0, ptr_r[idx]} + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = smp_r;
    if (st_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(clr_r);
      mem_wdata = '0;
    end else if (st_r == S_WR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= ring_mem[ring_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      num_ch_r    <= pac_pkg::RST_NUM_CHANNELS;
      sos_r       <= pac_pkg::RST_SPEED_OF_SOUND;
      ps_r        <= pac_pkg::RST_PRESSURE_SCALE;
      keep_r      <= pac_pkg::RST_FILTER_KEEP;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        ptr_r[c]  <= '0;
        sum_r[c]  <= '0;
        zoff_r[c] <= '0;
        filt_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pac_pkg::REG_NUM_CHANNELS:   num_ch_r <= cfg_wdata[2:0];
          pac_pkg::REG_SPEED_OF_SOUND: sos_r    <= cfg_wdata[15:0];
          pac_pkg::REG_PRESSURE_SCALE: ps_r     <= cfg_wdata;
          pac_pkg::REG_FILTER_KEEP:    keep_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      // S_OUT reloads the output register itself
      if (out_tready && st_r != S_OUT) out_valid_r <= 1'b0;

      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == DEPTH - 1) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_cmd;
            ch_r    <= in_ch;
            smp_r   <= in_smp;
            raw_r   <= '0;
            avg_r   <= '0;
            avgv_r  <= 1'b0;
            chbad_r <= !(32'(in_ch) < MAX_CHANNELS);
            if (!(32'(in_ch) < MAX_CHANNELS)) st_r <= S_OUT;
            else begin
              unique case (in_cmd)
                pac_pkg::CMD_STORE:  st_r <= S_RD;
                pac_pkg::CMD_OFFSET: st_r <= S_OFS;
                pac_pkg::CMD_ARM:    st_r <= S_AS;
                default: st_r <= S_OUT;
              endcase
            end
          end
        end
        S_RD: begin
          addr_r <= ring_addr;
          st_r   <= S_WR;
        end
        S_WR: begin
          sum_r[idx] <= sum_upd[SUMW-1:0];
          ptr_r[idx] <= (32'(ptr_inc) >= NUM_AVG) ? '0 : ptr_inc[PW-1:0];
          st_r       <= S_OUT;
        end
        S_OFS: begin
          zoff_r[idx] <= ofs_q[pac_pkg::SAMPLE_W-1:0];
          st_r        <= S_AS;
        end
        S_DIV: begin
          dnum_r <= dnum_r << 1;
          if (d_ge) begin
            drem_r <= DENW'(d_rs - {1'b0, dden_r});
            dq_r   <= {dq_r[DW-2:0], 1'b1};
          end else begin
            drem_r <= d_rs[DENW-1:0];
            dq_r   <= {dq_r[DW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == '0) begin
            avgv_r <= 1'b1;
            acc_r  <= '0;
            st_r   <= S_OUT;
            if (|dq_r[DW-2:15]) avg_r <= '1;
            else avg_r <= {dq_r[14:0], d_ge};
          end
        end
        S_AS: begin
          if (smp_r <= zoff_r[idx] || ps_r == '0) begin
            raw_r <= '0;
            st_r  <= (cmd_r == pac_pkg::CMD_ARM) ? S_FILT1 : S_OUT;
          end else begin
            base_r <= 46'(64'h1_0000_0000 + mul_p);
            sq_r   <= '0;
            sqc_r  <= '0;
            st_r   <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r  <= sq_r + sq_add;
          sqc_r <= sqc_r + 1'b1;
          if (sqc_r == 2'd3) begin
            y_r     <= '0;
            mask_r  <= 32'h8000_0000;
            pw_r[0] <= 32'h8000_0000;
            for (int j = 1; j < 7; j++) pw_r[j] <= '0;
            carry_r <= '0;
            wi_r    <= '0;
            pass_r  <= '0;
            st_r    <= S_RMUL;
          end
        end
        S_RMUL: begin
          pw_r[wi_r] <= mac[31:0];
          if (wi_r == 3'd6) begin
            carry_r <= '0;
            wi_r    <= '0;
            if (pass_r == 3'd5) st_r <= S_RCMP;
            else pass_r <= pass_r + 1'b1;
          end else begin
            carry_r <= mac[63:32];
            wi_r    <= wi_r + 1'b1;
          end
        end
        S_RCMP: begin
          y_r    <= y_new;
          mask_r <= mask_nxt;
          pass_r <= '0;
          if (mask_r[0]) begin
            st_r    <= S_SQRT;
            sv_r    <= 64'({kval, 28'b0});
            srem_r  <= '0;
            sroot_r <= '0;
            scnt_r  <= 5'd31;
          end else begin
            pw_r[0] <= y_new | mask_nxt;
            for (int j = 1; j < 7; j++) pw_r[j] <= '0;
            st_r <= S_RMUL;
          end
        end
        S_SQRT: begin
          sv_r <= sv_r << 2;
          if (s_rs >= s_trial) begin
            srem_r  <= s_rs - s_trial;
            sroot_r <= {sroot_r[30:0], 1'b1};
          end else begin
            srem_r  <= s_rs;
            sroot_r <= {sroot_r[30:0], 1'b0};
          end
          scnt_r <= scnt_r - 1'b1;
          if (scnt_r == '0) st_r <= S_SPD;
        end
        S_SPD: begin
          raw_r <= (|mul_p[63:42]) ? '1 : mul_p[41:26];
          st_r  <= (cmd_r == pac_pkg::CMD_ARM) ? S_FILT1 : S_OUT;
        end
        S_FILT1: begin
          t1_r <= mul_p[31:0];
          st_r <= S_FILT2;
        end
        S_FILT2: begin
          filt_r[idx] <= f_sum[31:16];
          st_r        <= S_ACC;
        end
        S_ACC: begin
          if (32'(ch_r) < 32'(cnt)) begin
            acc_r <= acc_sat;
            if (32'(ch_r) == 32'(cnt) - 1) begin
              dnum_r <= DW'(acc_sat);
              dden_r <= DENW'(cnt);
              drem_r <= '0;
              dq_r   <= '0;
              dcnt_r <= DCW'(DW - 1);
              st_r   <= S_DIV;
            end else st_r <= S_OUT;
          end else st_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_raw_r   <= raw_r;
            out_avg_r   <= avg_r;
            out_avgv_r  <= avgv_r;
            out_filt_r  <= chbad_r ? '0 : filt_r[idx];
            out_off_r   <= chbad_r ? '0 : zoff_r[idx];
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/pac_checker.sv -----
// Port-level checker for the pitot airspeed conditioner, bound to the top level.
// Depends on pitot_airspeed_conditioner_top ports only.
module pac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // mean field is zero unless flagged
  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[47:32] == 16'd0)
    else $error("speed_average set without average_valid");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // reset empties the output and starts the clearing pass
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("reset left output valid or input ready");

endmodule

bind pitot_airspeed_conditioner_top pac_checker u_pac_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

// ----- test/tb_pitot_airspeed_conditioner_top.sv -----
// Self-checking testbench for pitot_airspeed_conditioner_top: a directed table, then
// random calibration, offset and armed sweeps, checked item by item against a predictor.
// Depends on pac_pkg and the RTL top level.
module tb_pitot_airspeed_conditioner_top;

  localparam logic [pac_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;  // no command, must be ignored
  localparam int RING_LEN  = pac_pkg::DEF_NUM_AVG;
  localparam int CHANNELS  = pac_pkg::DEF_MAX_CHANNELS;
  localparam int RAND_ITEMS = 1525;
  localparam int IDLE_LIMIT = 20000;  // watchdog limit, well above the longest armed item

  typedef struct packed {
    logic [15:0] raw;
    logic [15:0] filt;
    logic [15:0] avg;
    logic        valid;
    logic [12:0] off;
  } speed_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [1:0]      cmd;
    logic [1:0]      ch;
    logic [12:0]     smp;
    logic [1:0]      idx;
    logic [31:0]     data;
    logic            typed;   // expectation given in the row
    speed_res_t      res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;

  pitot_airspeed_conditioner_top u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always #2 clk = ~clk;

  // Predictor copy of the block's configuration and state
  logic [2:0]  p_nchan;
  logic [15:0] p_sos;
  logic [31:0] p_scale;
  logic [15:0] p_keep;
  logic [12:0] p_ring [CHANNELS][RING_LEN];
  logic [5:0]  p_ptr  [CHANNELS];
  logic [18:0] p_sum  [CHANNELS];
  logic [12:0] p_off  [CHANNELS];
  logic [15:0] p_filt [CHANNELS];
  logic [17:0] p_acc;

  speed_res_t speed_q[$];   // expected results, oldest first
  int errors = 0;
  int n_sent = 0, n_rcvd = 0, n_armed = 0, n_avg = 0, n_phases = 0;
  bit quiet = 1'b0;         // no idling on either side near the end
  bit stim_done = 1'b0;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // a*sqrt(5*((1+ratio)^(2/7)-1)), exact integer form, Q8.8 saturating
  function automatic logic [15:0] pitot_speed(logic [12:0] smp, logic [12:0] off);
    logic [255:0] base, target, pw;
    logic [63:0]  lo, hi, mid, k, s, sp;
    if (smp <= off || p_scale == 0) return 16'd0;
    base = 256'(64'd1 << 32) + 256'(64'(smp - off) * 64'(p_scale));
    target = (base * base) << 132;
    lo = 64'd1 << 28;
    hi = 64'hFFFF_FFFF;
    // largest Y with Y^7 <= base^2 * 2^132
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      pw = 256'(mid);
      pw = pw * pw * pw * pw * pw * pw * pw;
      if (pw <= target) lo = mid;
      else hi = mid - 1;
    end
    k = 5 * (lo - (64'd1 << 28));
    s = root64(k << 28);
    sp = (64'(p_sos) * s) >> 26;
    return (sp > 65535) ? 16'hFFFF : sp[15:0];
  endfunction

  function automatic speed_res_t predict_speed(logic [1:0] cmd, logic [1:0] ch,
                                               logic [12:0] smp);
    speed_res_t r;
    int unsigned cnt, a;
    logic [63:0] f;
    r = '0;
    cnt = (p_nchan < 1) ? 1 : (p_nchan > CHANNELS) ? CHANNELS : p_nchan;
    case (cmd)
      pac_pkg::CMD_STORE: begin
        p_sum[ch] = p_sum[ch] - p_ring[ch][p_ptr[ch]] + smp;
        p_ring[ch][p_ptr[ch]] = smp;
        p_ptr[ch] = p_ptr[ch] + 1;  // wraps at RING_LEN = 64
      end
      pac_pkg::CMD_OFFSET: begin
        p_off[ch] = 13'(p_sum[ch] / RING_LEN);
        r.raw = pitot_speed(smp, p_off[ch]);
      end
      pac_pkg::CMD_ARM: begin
        r.raw = pitot_speed(smp, p_off[ch]);
        f = (64'(p_keep) * p_filt[ch] + 64'(65536 - p_keep) * r.raw + 32768) >> 16;
        p_filt[ch] = (f > 65535) ? 16'hFFFF : f[15:0];
        if (ch < cnt) begin
          a = p_acc + p_filt[ch];
          p_acc = (a > pac_pkg::ACC_MAX) ? pac_pkg::ACC_MAX : a[17:0];
          if (ch == cnt - 1) begin
            a = p_acc / cnt;
            r.avg = (a > 65535) ? 16'hFFFF : a[15:0];
            r.valid = 1'b1;
            p_acc = '0;
          end
        end
      end
      default: ;
    endcase
    r.filt = p_filt[ch];
    r.off = p_off[ch];
    return r;
  endfunction

  // Offer one item; the expectation is queued at the accepting edge
  task automatic send_item(logic [1:0] cmd, logic [1:0] ch, logic [12:0] smp,
                           bit typed = 0, speed_res_t given = '0);
    speed_res_t r;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, smp, ch};
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    r = predict_speed(cmd, ch, smp);
    speed_q.push_back(typed ? given : r);
    n_sent++;
    if (cmd == pac_pkg::CMD_ARM) n_armed++;
  endtask

  // Registers change only with the block idle and nothing in flight
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (speed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pac_pkg::REG_NUM_CHANNELS:   p_nchan = val[2:0];
      pac_pkg::REG_SPEED_OF_SOUND: p_sos = val[15:0];
      pac_pkg::REG_PRESSURE_SCALE: p_scale = val;
      pac_pkg::REG_FILTER_KEEP:    p_keep = val[15:0];
      default: ;
    endcase
  endtask

  // Directed table. Typed expectations only where they are obvious:
  // reset state, zero pressure scale, sample equal to offset.
  dir_row_t dir_rows[24] = '{
    '{ROW_ITEM, pac_pkg::CMD_STORE,  2'd0, 13'd0,    2'd0, 32'd0, 1'b1, '0},
    '{ROW_ITEM, pac_pkg::CMD_STORE,  2'd3, 13'd8191, 2'd0, 32'd0, 1'b1, '0},
    '{ROW_ITEM, CMD_UNUSED,          2'd1, 13'd8191, 2'd0, 32'd0, 1'b1, '0},
    // zero scale: no speed, but channel 0 is the last of one channel
    '{ROW_ITEM, pac_pkg::CMD_ARM,    2'd0, 13'd100,  2'd0, 32'd0, 1'b1,
      '{16'd0, 16'd0, 16'd0, 1'b1, 13'd0}},
    // beyond channel count: not accumulated
    '{ROW_ITEM, pac_pkg::CMD_ARM,    2'd1, 13'd8191, 2'd0, 32'd0, 1'b1, '0},
    // ring mean of channel 3 is 8191/64
    '{ROW_ITEM, pac_pkg::CMD_OFFSET, 2'd3, 13'd8191, 2'd0, 32'd0, 1'b1,
      '{16'd0, 16'd0, 16'd0, 1'b0, 13'd127}},
    '{ROW_CFG,  2'd0, 2'd0, 13'd0, pac_pkg::REG_NUM_CHANNELS,   32'd4,         1'b0, '0},
    '{ROW_CFG,  2'd0, 2'd0, 13'd0, pac_pkg::REG_PRESSURE_SCALE, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_CFG,  2'd0, 2'd0, 13'd0, pac_pkg::REG_SPEED_OF_SOUND, 32'd65535,     1'b0, '0},
    '{ROW_CFG,  2'd0, 2'd0, 13'd0, pac_pkg::REG_FILTER_KEEP,    32'd0,         1'b0, '0},
    // sample equal to offset: no speed; last channel with empty accumulator
    '{ROW_ITEM, pac_pkg::CMD_ARM,    2'd3, 13'd127,  2'd0, 32'd0, 1'b1,
      '{16'd0, 16'd0, 16'd0, 1'b1, 13'd127}},
    '{ROW_ITEM, pac_pkg::CMD_ARM,    2'd0, 13'd8191, 2'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, pac_pkg::CMD_ARM,    2'd1, 13'd1,    2'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, pac_pkg::CMD_ARM,    2'd2, 13'd4096, 2'd0, 32'd0, 1'b0, '0},
    '{ROW_ITEM, pac_pkg::CMD_ARM,    2'd3, 13'd8191, 2'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG,  2'd0, 2'd0, 13'd0, pac_pkg::REG_FILTER_KEEP,    32'd65535,     1'b0, '0},
    '{ROW_CFG,  2'd0, 2'd0, 13'd0, pac_pkg::REG_PRESSURE_SCALE, 32'd1,         1'b0, '0},
    '{ROW_ITEM, pac_pkg::CMD_ARM,    2'd3, 13'd128,  2'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG,  2'd0, 2'd0, 13'd0, pac_pkg::REG_NUM_CHANNELS,   32'd0,         1'b0, '0},
    '{ROW_ITEM, pac_pkg::CMD_ARM,    2'd0, 13'd8191, 2'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG,  2'd0, 2'd0, 13'd0, pac_pkg::REG_NUM_CHANNELS,   32'd7,         1'b0, '0},
    '{ROW_ITEM, pac_pkg::CMD_OFFSET, 2'd2, 13'd0,    2'd0, 32'd0, 1'b0, '0},
    '{ROW_CFG,  2'd0, 2'd0, 13'd0, pac_pkg::REG_SPEED_OF_SOUND, 32'd0,         1'b0, '0},
    '{ROW_ITEM, pac_pkg::CMD_ARM,    2'd1, 13'd8191, 2'd0, 32'd0, 1'b0, '0}
  };

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(1, 4096));
      3: return 32'($urandom_range(1, 1 << 20)) << $urandom_range(0, 11);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [12:0] pick_sample(logic [1:0] ch);
    int unsigned v;
    if ($urandom_range(0, 3) == 0) begin
      // hug the zero offset: below, equal and just above
      v = p_off[ch] + $urandom_range(0, 4);
      v = (v < 2) ? 0 : v - 2;
      return (v > 8191) ? 13'd8191 : v[12:0];
    end
    return 13'($urandom);
  endfunction

  // Main stimulus
  initial begin
    int cnt, len, start;
    logic [1:0] ch;
    p_nchan = pac_pkg::RST_NUM_CHANNELS;
    p_sos = pac_pkg::RST_SPEED_OF_SOUND;
    p_scale = pac_pkg::RST_PRESSURE_SCALE;
    p_keep = pac_pkg::RST_FILTER_KEEP;
    foreach (p_ring[i, j]) p_ring[i][j] = '0;
    foreach (p_ptr[i]) begin
      p_ptr[i] = '0;
      p_sum[i] = '0;
      p_off[i] = '0;
      p_filt[i] = '0;
    end
    p_acc = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].smp,
                  dir_rows[i].typed, dir_rows[i].res);
      end
    end

    start = n_sent;
    while (n_sent - start < RAND_ITEMS) begin
      drain();
      n_phases++;
      if (n_sent - start > RAND_ITEMS - 150) quiet = 1'b1;
      write_reg(pac_pkg::REG_NUM_CHANNELS, 32'($urandom_range(0, 7)));
      write_reg(pac_pkg::REG_SPEED_OF_SOUND, ($urandom_range(0, 5) == 0) ?
                32'($urandom_range(0, 1) * 16'hFFFF) : 32'($urandom_range(0, 65535)));
      write_reg(pac_pkg::REG_PRESSURE_SCALE, pick_scale());
      write_reg(pac_pkg::REG_FILTER_KEEP, ($urandom_range(0, 4) == 0) ?
                32'($urandom_range(0, 1) * 16'hFFFF) : 32'($urandom_range(0, 65535)));
      cnt = (p_nchan < 1) ? 1 : (p_nchan > CHANNELS) ? CHANNELS : p_nchan;
      len = n_sent + $urandom_range(60, 120);
      while (n_sent < len && n_sent - start < RAND_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // armed sweep over the channels in use, sometimes joined midway
            for (int c = $urandom_range(0, 3) == 0 ? $urandom_range(0, cnt - 1) : 0;
                 c < cnt; c++)
              send_item(pac_pkg::CMD_ARM, c[1:0], pick_sample(c[1:0]));
          end
          5, 6, 7: begin
            // calibration: a burst of disarmed samples, then set the offset
            ch = 2'($urandom);
            repeat ($urandom_range(3, 70)) send_item(pac_pkg::CMD_STORE, ch, 13'($urandom));
            send_item(pac_pkg::CMD_OFFSET, ch, 13'($urandom));
          end
          default: begin
            // noise: any command on any channel
            send_item(2'($urandom), 2'($urandom), 13'($urandom));
          end
        endcase
      end
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: checks, random stalls and one long hold-off
  initial begin
    int hold = 0;
    bit held_long = 0;
    speed_res_t got, want;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser[0],
                out_tdata[60:48]};
        if (speed_q.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got);
          errors++;
        end else begin
          want = speed_q.pop_front();
          if (got.raw !== want.raw || got.filt !== want.filt || got.avg !== want.avg ||
              got.valid !== want.valid || got.off !== want.off || out_tdata[63:61] !== 0) begin
            $display("%0t: mismatch exp raw=%0d filt=%0d avg=%0d valid=%0d off=%0d",
                     $time, want.raw, want.filt, want.avg, want.valid, want.off);
            $display("%0t:          got raw=%0d filt=%0d avg=%0d valid=%0d off=%0d",
                     $time, got.raw, got.filt, got.avg, got.valid, got.off);
            errors++;
          end
        end
        n_rcvd++;
        if (got.valid) n_avg++;
      end
      // long hold-off so the output register fills and the input stalls
      if (!held_long && n_rcvd == 250) begin
        held_long = 1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  initial begin
    int idle = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("[pitot_airspeed_conditioner_top] ERROR");
        $finish;
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (speed_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d items (%0d armed, %0d averages) over %0d register settings",
             n_sent, n_armed, n_avg, n_phases + 1);
    if (errors == 0) begin
      $display("[pitot_airspeed_conditioner_top] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[pitot_airspeed_conditioner_top] ERROR");
    end
    $finish;
  end

endmodule
